// File: src/byte_stream_tokenizer_macros.svh
// assertion macros for the byte stream tokenizer
// expects clk and rst_n in the scope of use
`ifndef BYTE_STREAM_TOKENIZER_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bst assertion failed");

// next-cycle implication, checked out of reset
`define BST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bst assertion failed");

`endif

// File: src/bst_pkg.sv
// shared types, token codes and character decoders for the byte stream tokenizer
// no dependencies
`timescale 1ns / 1ps

package bst_pkg;

  localparam int MAX_KEYWORD_LEN_DEF = 5;
  localparam int POSITION_BITS_DEF   = 24;
  localparam int LENGTH_BITS_DEF     = 16;

  localparam int KIND_W   = 5;
  localparam int OFFSET_W = 24;
  localparam int LEN_W    = 16;
  localparam int VALUE_W  = 64;
  localparam int LINE_W   = 24;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t TK_INT     = 5'd0;
  localparam kind_t TK_LET     = 5'd1;
  localparam kind_t TK_IF      = 5'd2;
  localparam kind_t TK_FOR     = 5'd3;
  localparam kind_t TK_WHILE   = 5'd4;
  localparam kind_t TK_FN      = 5'd5;
  localparam kind_t TK_IDENT   = 5'd6;
  localparam kind_t TK_NUMBER  = 5'd7;
  localparam kind_t TK_PLUS    = 5'd8;
  localparam kind_t TK_MINUS   = 5'd9;
  localparam kind_t TK_SLASH   = 5'd10;
  localparam kind_t TK_STAR    = 5'd11;
  localparam kind_t TK_LBRACE  = 5'd12;
  localparam kind_t TK_RBRACE  = 5'd13;
  localparam kind_t TK_LPAREN  = 5'd14;
  localparam kind_t TK_RPAREN  = 5'd15;
  localparam kind_t TK_COMMA   = 5'd16;
  localparam kind_t TK_GT      = 5'd17;
  localparam kind_t TK_LT      = 5'd18;
  localparam kind_t TK_GE      = 5'd19;
  localparam kind_t TK_LE      = 5'd20;
  localparam kind_t TK_EQEQ    = 5'd21;
  localparam kind_t TK_NE      = 5'd22;
  localparam kind_t TK_BANG    = 5'd23;
  localparam kind_t TK_ASSIGN  = 5'd24;
  localparam kind_t TK_SEMI    = 5'd25;
  localparam kind_t TK_COLON   = 5'd26;
  localparam kind_t TK_EOF     = 5'd27;
  localparam kind_t TK_UNKNOWN = 5'd28;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = "=";
  localparam logic [7:0] CH_USC = "_";

  // keyword table, padded with zero bytes
  localparam int KW_COUNT = 6;
  localparam int KW_MAX   = 5;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
    '{"l", "e", "t", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"f", "n", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00}
  };
  localparam int    KW_LEN  [KW_COUNT] = '{3, 2, 3, 5, 2, 3};
  localparam kind_t KW_KIND [KW_COUNT] = '{TK_LET, TK_IF, TK_FOR, TK_WHILE, TK_FN, TK_INT};

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_OPER
  } mode_t;

  typedef struct packed {
    kind_t                    kind;
    logic [OFFSET_W-1:0]      offset;
    logic [LEN_W-1:0]         length;
    logic signed [VALUE_W-1:0] value;
    logic [LINE_W-1:0]        line;
    logic                     last;
  } tok_t;

  // tokens made by one byte, in order a then b
  typedef struct packed {
    logic [1:0] n;
    tok_t       a;
    tok_t       b;
  } push_t;

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "/":     k = TK_SLASH;
      "*":     k = TK_STAR;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMI;
      ":":     k = TK_COLON;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_t oper_kind(input logic [7:0] c, input logic with_eq);
    kind_t k;
    unique case (c)
      ">":     k = with_eq ? TK_GE   : TK_GT;
      "<":     k = with_eq ? TK_LE   : TK_LT;
      "=":     k = with_eq ? TK_EQEQ : TK_ASSIGN;
      "!":     k = with_eq ? TK_NE   : TK_BANG;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    logic s;
    unique case (c) inside
      CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: s = 1'b1;
      default:                                   s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// File: src/bst_lexer.sv
// scanner state and per-byte token logic for the byte stream tokenizer
// depends on bst_pkg
`timescale 1ns / 1ps

module bst_lexer #(
  parameter int MAX_KEYWORD_LEN = bst_pkg::MAX_KEYWORD_LEN_DEF,
  parameter int POSITION_BITS   = bst_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS     = bst_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    text_byte,
  output bst_pkg::push_t push
);
  import bst_pkg::*;

  localparam int OW = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
  localparam int LW = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
  localparam int KP = (MAX_KEYWORD_LEN > KW_MAX) ? MAX_KEYWORD_LEN : KW_MAX;

  mode_t                    mode_r, mode_nxt;
  logic [7:0]               pend_r, pend_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0]   run_r, run_nxt;
  logic [VALUE_W-1:0]       acc_r, acc_nxt;
  logic [7:0]               chars_r   [MAX_KEYWORD_LEN];
  logic [7:0]               chars_nxt [MAX_KEYWORD_LEN];
  logic [LINE_W-1:0]        line_r, line_nxt;

  logic       is_alpha, is_digit, is_idchar, is_oper, is_single, is_zero, is_eq;
  logic       cont, oper_eq, fresh;
  kind_t      sgl_kind, id_kind;
  logic [7:0] chars_pad [KP];
  logic [KW_COUNT-1:0] kw_hit;
  logic [OW-1:0] start_ext, pos_ext;
  logic [LW-1:0] run_ext;
  tok_t       tok_f, tok_g;
  logic       f_on, g_on;

  assign is_alpha  = ((text_byte >= "a") && (text_byte <= "z")) ||
                     ((text_byte >= "A") && (text_byte <= "Z"));
  assign is_digit  = (text_byte >= "0") && (text_byte <= "9");
  assign is_idchar = is_alpha || is_digit || (text_byte == CH_USC);
  assign sgl_kind  = single_kind(text_byte);
  assign is_single = (sgl_kind != TK_UNKNOWN);
  assign is_oper   = (oper_kind(text_byte, 1'b0) != TK_UNKNOWN);
  assign is_zero   = (text_byte == CH_NUL);
  assign is_eq     = (text_byte == CH_EQ);

  assign cont    = ((mode_r == MODE_IDENT) && is_idchar) ||
                   ((mode_r == MODE_NUMBER) && is_digit);
  assign oper_eq = (mode_r == MODE_OPER) && is_eq;
  assign fresh   = !cont && !oper_eq;

  assign start_ext = OW'(start_r);
  assign pos_ext   = OW'(pos_r);
  assign run_ext   = LW'(run_r);

  // keyword compare window
  for (genvar i = 0; i < KP; i++) begin : g_pad
    if (i < MAX_KEYWORD_LEN) begin : g_char
      assign chars_pad[i] = chars_r[i];
    end else begin : g_zero
      assign chars_pad[i] = 8'h00;
    end
  end

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_hit[k] = (run_r == LENGTH_BITS'(KW_LEN[k])) && (KW_LEN[k] <= MAX_KEYWORD_LEN);
      for (int i = 0; i < KW_MAX; i++) begin
        if ((i < KW_LEN[k]) && (chars_pad[i] != KW_TEXT[k][i])) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
    id_kind = TK_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        id_kind = KW_KIND[k];
      end
    end
  end

  // next scan mode
  always_comb begin
    mode_nxt = mode_r;
    if (step) begin
      if (!fresh) begin
        unique case (mode_r)
          MODE_IDENT, MODE_NUMBER: mode_nxt = mode_r;
          default:                 mode_nxt = MODE_IDLE;
        endcase
      end else if (is_oper) begin
        mode_nxt = MODE_OPER;
      end else if (is_alpha) begin
        mode_nxt = MODE_IDENT;
      end else if (is_digit) begin
        mode_nxt = MODE_NUMBER;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end
  end

  // datapath and tokens
  always_comb begin
    pend_nxt  = pend_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    chars_nxt = chars_r;
    line_nxt  = line_r;
    tok_f     = '0;
    tok_g     = '0;
    f_on      = 1'b0;
    g_on      = 1'b0;

    tok_f.offset = start_ext[OFFSET_W-1:0];
    tok_f.line   = line_r;
    tok_g.offset = pos_ext[OFFSET_W-1:0];
    tok_g.line   = line_r;

    if (step) begin
      if (pos_r != '1) begin
        pos_nxt = pos_r + 1'b1;
      end

      unique case (mode_r)
        MODE_IDENT: begin
          if (is_idchar) begin
            for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
              if (run_r == LENGTH_BITS'(i)) begin
                chars_nxt[i] = text_byte;
              end
            end
            if (run_r != '1) begin
              run_nxt = run_r + 1'b1;
            end
          end else begin
            f_on         = 1'b1;
            tok_f.kind   = id_kind;
            tok_f.length = run_ext[LEN_W-1:0];
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + VALUE_W'(text_byte[3:0]);
            if (run_r != '1) begin
              run_nxt = run_r + 1'b1;
            end
          end else begin
            f_on         = 1'b1;
            tok_f.kind   = TK_NUMBER;
            tok_f.length = run_ext[LEN_W-1:0];
            tok_f.value  = $signed(acc_r);
          end
        end
        MODE_OPER: begin
          f_on         = 1'b1;
          tok_f.kind   = oper_kind(pend_r, is_eq);
          tok_f.length = is_eq ? LEN_W'(2) : LEN_W'(1);
          pend_nxt     = 8'h00;
        end
        default: begin
        end
      endcase

      if (fresh) begin
        if (is_zero) begin
          g_on         = 1'b1;
          tok_g.kind   = TK_EOF;
          tok_g.length = '0;
          pend_nxt     = 8'h00;
          pos_nxt      = '0;
          start_nxt    = '0;
          run_nxt      = '0;
          acc_nxt      = '0;
          chars_nxt    = '{default: 8'h00};
          line_nxt     = LINE_W'(1);
        end else if (is_space(text_byte)) begin
          if ((text_byte == CH_LF) && (line_r != '1)) begin
            line_nxt = line_r + 1'b1;
          end
        end else if (is_single) begin
          g_on         = 1'b1;
          tok_g.kind   = sgl_kind;
          tok_g.length = LEN_W'(1);
        end else if (is_oper) begin
          pend_nxt  = text_byte;
          start_nxt = pos_r;
          run_nxt   = LENGTH_BITS'(1);
        end else if (is_alpha) begin
          chars_nxt    = '{default: 8'h00};
          chars_nxt[0] = text_byte;
          start_nxt    = pos_r;
          run_nxt      = LENGTH_BITS'(1);
        end else if (is_digit) begin
          start_nxt = pos_r;
          run_nxt   = LENGTH_BITS'(1);
          acc_nxt   = VALUE_W'(text_byte[3:0]);
        end else begin
          g_on         = 1'b1;
          tok_g.kind   = TK_UNKNOWN;
          tok_g.length = LEN_W'(1);
        end
      end
    end
  end

  // order tokens, flush first
  always_comb begin
    push.n      = {f_on & g_on, f_on ^ g_on};
    push.a      = f_on ? tok_f : tok_g;
    push.a.last = !(f_on && g_on);
    push.b      = tok_g;
    push.b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pend_r  <= 8'h00;
      pos_r   <= '0;
      start_r <= '0;
      run_r   <= '0;
      acc_r   <= '0;
      chars_r <= '{default: 8'h00};
      line_r  <= LINE_W'(1);
    end else begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      run_r   <= run_nxt;
      acc_r   <= acc_nxt;
      chars_r <= chars_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// File: src/bst_tok_fifo.sv
// small token queue, takes up to two tokens a cycle and hands out one
// depends on bst_pkg
`timescale 1ns / 1ps

module bst_tok_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  bst_pkg::push_t  push,
  input  logic            pop,
  output bst_pkg::tok_t   head,
  output logic            head_vld,
  output logic            room2
);
  import bst_pkg::*;

  tok_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_inc;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign wr_inc   = wr_r + 1'b1;
  assign head     = mem_r[rd_r];
  assign head_vld = (cnt_r != '0);
  assign room2    = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_nxt  = wr_r + FIFO_PTR_W'(push.n);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_inc] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/byte_stream_tokenizer.sv
// top level of the byte stream tokenizer: input word register, lexer, token queue
// depends on bst_pkg, bst_lexer, bst_tok_fifo and byte_stream_tokenizer_macros.svh
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | text_byte
//   out_    | output    | out_valid/out_stall| token kind, offset, length, value, line, last
//
// one word per cycle when not stalled; a word making two tokens takes an extra queue slot
// a word waits in the input register; the lexer then writes its tokens into the queue
// the four-entry token queue sets the rate: words stall while fewer than two slots are free
// reset is synchronous and clears the scanner, the queue pointers and the input valid flag
// out_stall holds the queue head; input flows on while at least two queue slots are free
`timescale 1ns / 1ps
`include "byte_stream_tokenizer_macros.svh"

module byte_stream_tokenizer #(
  parameter int MAX_KEYWORD_LEN = bst_pkg::MAX_KEYWORD_LEN_DEF,
  parameter int POSITION_BITS   = bst_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS     = bst_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_text_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bst_pkg::KIND_W-1:0]         out_token_kind,
  output logic [bst_pkg::OFFSET_W-1:0]       out_token_offset,
  output logic [bst_pkg::LEN_W-1:0]          out_token_length,
  output logic signed [bst_pkg::VALUE_W-1:0] out_number_value,
  output logic [bst_pkg::LINE_W-1:0]         out_token_line,
  output logic                               out_last_of_run
);
  import bst_pkg::*;

  logic [7:0] byte_r;
  logic       byte_vld_r, byte_vld_nxt;
  logic       room2, step, accept, pop, head_vld;
  push_t      push;
  tok_t       head;

  assign step     = byte_vld_r && room2;
  assign in_stall = byte_vld_r && !room2;
  assign accept   = in_valid && !in_stall;
  assign pop      = head_vld && !out_stall;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (accept) begin
      byte_vld_nxt = 1'b1;
    end else if (step) begin
      byte_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
    end
  end

  bst_lexer #(
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
    .POSITION_BITS   (POSITION_BITS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (byte_r),
    .push      (push)
  );

  bst_tok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .head_vld (head_vld),
    .room2    (room2)
  );

  assign out_valid        = head_vld;
  assign out_token_kind   = head.kind;
  assign out_token_offset = head.offset;
  assign out_token_length = head.length;
  assign out_number_value = head.value;
  assign out_token_line   = head.line;
  assign out_last_of_run  = head.last;

  `BST_ASSERT_SAME(a_push_only_on_step, push.n != 2'd0, step)
  `BST_ASSERT_SAME(a_eof_closes_run, step && (byte_r == CH_NUL), (push.n != 2'd0) && ((push.n == 2'd2 ? push.b.kind : push.a.kind) == TK_EOF))
  `BST_ASSERT_SAME(a_pair_last_flags, push.n == 2'd2, !push.a.last && push.b.last)
  `BST_ASSERT_NEXT(a_push_shows_token, push.n != 2'd0, out_valid)

endmodule

// File: tb/byte_stream_tokenizer_tb.sv
// self-checking testbench for byte_stream_tokenizer: drives text words, predicts the tokens
// depends on bst_pkg and the byte_stream_tokenizer rtl
`timescale 1ns / 1ps

module byte_stream_tokenizer_tb;
  import bst_pkg::*;

  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_WORDS   = 830;
  localparam int STEADY_WORDS   = 150;
  localparam int LONG_IDENT_LEN = 40;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [7:0]                  in_text_byte;
  logic                        out_valid;
  logic                        out_stall;
  logic [KIND_W-1:0]           out_token_kind;
  logic [OFFSET_W-1:0]         out_token_offset;
  logic [LEN_W-1:0]            out_token_length;
  logic signed [VALUE_W-1:0]   out_number_value;
  logic [LINE_W-1:0]           out_token_line;
  logic                        out_last_of_run;

  byte_stream_tokenizer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_offset (out_token_offset),
    .out_token_length (out_token_length),
    .out_number_value (out_number_value),
    .out_token_line   (out_token_line),
    .out_last_of_run  (out_last_of_run)
  );

  always #5 clk = ~clk;

  // predicted scanner state
  mode_t               scan_state;
  logic [7:0]          held_op;
  logic [OFFSET_W-1:0] next_pos;
  logic [OFFSET_W-1:0] tok_start;
  logic [LEN_W-1:0]    tok_len;
  logic [VALUE_W-1:0]  num_acc;
  logic [7:0]          kw_buf [5];
  logic [LINE_W-1:0]   line_no;

  tok_t        token_q [$];
  tok_t        want_tok;
  int          error_count;
  int          words_sent;
  int          tokens_checked;
  int          cycle_count;
  logic [31:0] kinds_seen;
  bit          idle_on;
  bit          hold_request;

  string       letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string       word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string       lone_ops   = "+-/*{}(),;:";
  string       pair_ops   = "><=!";
  logic [7:0]  blanks [6] = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  task automatic reset_scanner();
    scan_state = MODE_IDLE;
    held_op    = '0;
    next_pos   = '0;
    tok_start  = '0;
    tok_len    = '0;
    num_acc    = '0;
    foreach (kw_buf[i]) kw_buf[i] = '0;
    line_no    = 1;
  endtask

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic kind_t lone_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "/":     k = TK_SLASH;
      "*":     k = TK_STAR;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMI;
      ":":     k = TK_COLON;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] c, input logic with_eq);
    kind_t k;
    case (c)
      ">":     k = with_eq ? TK_GE : TK_GT;
      "<":     k = with_eq ? TK_LE : TK_LT;
      "=":     k = with_eq ? TK_EQEQ : TK_ASSIGN;
      "!":     k = with_eq ? TK_NE : TK_BANG;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_t word_kind();
    logic [39:0] head;
    kind_t       k;
    head = {kw_buf[0], kw_buf[1], kw_buf[2], kw_buf[3], kw_buf[4]};
    k = TK_IDENT;
    case (tok_len)
      16'd2: begin
        if (head[39:24] == "if") k = TK_IF;
        else if (head[39:24] == "fn") k = TK_FN;
      end
      16'd3: begin
        if (head[39:16] == "let") k = TK_LET;
        else if (head[39:16] == "for") k = TK_FOR;
        else if (head[39:16] == "int") k = TK_INT;
      end
      16'd5: begin
        if (head == "while") k = TK_WHILE;
      end
      default: ;
    endcase
    return k;
  endfunction

  function automatic tok_t make_tok(input kind_t k, input logic [OFFSET_W-1:0] off,
                                    input logic [LEN_W-1:0] len, input logic [VALUE_W-1:0] val);
    tok_t t;
    t.kind   = k;
    t.offset = off;
    t.length = len;
    t.value  = val;
    t.line   = line_no;
    t.last   = 1'b0;
    return t;
  endfunction

  // tokens caused by one accepted word, appended to token_q in order
  task automatic predict_word(input logic [7:0] b);
    tok_t                made [2];
    int                  n;
    logic [OFFSET_W-1:0] here;
    logic                rest;
    n = 0;
    rest = 1'b1;
    here = next_pos;
    if (next_pos != '1) next_pos++;
    case (scan_state)
      MODE_IDENT: begin
        if (is_letter(b) || is_digit(b) || b == CH_USC) begin
          if (tok_len < 5) kw_buf[tok_len] = b;
          if (tok_len != '1) tok_len++;
          rest = 1'b0;
        end else begin
          made[n] = make_tok(word_kind(), tok_start, tok_len, '0);
          n++;
          scan_state = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(b)) begin
          num_acc = num_acc * 64'd10 + {56'd0, b - 8'h30};
          if (tok_len != '1) tok_len++;
          rest = 1'b0;
        end else begin
          made[n] = make_tok(TK_NUMBER, tok_start, tok_len, num_acc);
          n++;
          scan_state = MODE_IDLE;
        end
      end
      MODE_OPER: begin
        scan_state = MODE_IDLE;
        if (b == CH_EQ) begin
          made[n] = make_tok(pair_kind(held_op, 1'b1), tok_start, 2, '0);
          n++;
          rest = 1'b0;
        end else begin
          made[n] = make_tok(pair_kind(held_op, 1'b0), tok_start, 1, '0);
          n++;
        end
        held_op = '0;
      end
      default: ;
    endcase
    if (rest) begin
      if (b == CH_NUL) begin
        made[n] = make_tok(TK_EOF, here, 0, '0);
        n++;
        reset_scanner();
      end else if (is_blank(b)) begin
        if (b == CH_LF && line_no != '1) line_no++;
      end else if (lone_kind(b) != TK_UNKNOWN) begin
        made[n] = make_tok(lone_kind(b), here, 1, '0);
        n++;
      end else if (pair_kind(b, 1'b0) != TK_UNKNOWN) begin
        scan_state = MODE_OPER;
        held_op = b;
        tok_start = here;
        tok_len = 1;
      end else if (is_letter(b)) begin
        foreach (kw_buf[i]) kw_buf[i] = '0;
        kw_buf[0] = b;
        scan_state = MODE_IDENT;
        tok_start = here;
        tok_len = 1;
      end else if (is_digit(b)) begin
        scan_state = MODE_NUMBER;
        tok_start = here;
        tok_len = 1;
        num_acc = {56'd0, b - 8'h30};
      end else begin
        made[n] = make_tok(TK_UNKNOWN, here, 1, '0);
        n++;
      end
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) token_q.push_back(made[i]);
  endtask

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_word(b);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic string keyword_text(input int i);
    string s;
    case (i)
      0:       s = "let";
      1:       s = "if";
      2:       s = "for";
      3:       s = "while";
      4:       s = "fn";
      default: s = "int";
    endcase
    return s;
  endfunction

  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_text(keyword_text($urandom_range(0, 5)));
      if ($urandom_range(0, 2) == 0) send_word(word_chars[$urandom_range(0, 62)]);
    end else if (pick < 35) begin
      n = $urandom_range(1, 8);
      send_word(letters[$urandom_range(0, 51)]);
      repeat (n - 1) send_word(word_chars[$urandom_range(0, 62)]);
    end else if (pick < 52) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 4);
      repeat (n) send_word(8'h30 + 8'($urandom_range(0, 9)));
    end else if (pick < 64) begin
      send_word(lone_ops[$urandom_range(0, 10)]);
    end else if (pick < 76) begin
      send_word(pair_ops[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1) == 0) send_word(CH_EQ);
    end else if (pick < 90) begin
      send_word(blanks[$urandom_range(0, 5)]);
    end else if (pick < 98) begin
      send_word(8'($urandom_range(1, 255)));
    end else begin
      send_word(CH_NUL);
    end
  endtask

  task automatic test_directed_text();
    send_text("while fn<=x!99");
    send_word(8'hFF);
    send_text("_\n==(");
    send_word(8'h7F);
    send_word(8'h80);
    send_word(8'h01);
    send_text("7");
    send_word(CH_NUL);
    wait_drained();
  endtask

  task automatic test_long_identifier();
    send_word("q");
    repeat (LONG_IDENT_LEN - 1) send_word(word_chars[$urandom_range(0, 62)]);
    send_text(";int");
    send_word(CH_NUL);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (40) send_word("+");
    send_text("x1 >= 7;");
    send_word(CH_NUL);
    wait_drained();
  endtask

  task automatic test_random_text();
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) send_random_token();
    send_word(CH_NUL);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    int target;
    idle_on = 1'b0;
    target = words_sent + STEADY_WORDS;
    while (words_sent < target) send_random_token();
    send_word(CH_NUL);
    wait_drained();
  endtask

  // result-side stall: short random bursts, or one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                 $time, out_token_kind, out_token_offset);
        error_count++;
      end else begin
        want_tok = token_q.pop_front();
        check_field("kind", want_tok.kind, out_token_kind);
        check_field("offset", want_tok.offset, out_token_offset);
        check_field("length", want_tok.length, out_token_length);
        check_field("value", want_tok.value, out_number_value);
        check_field("line", want_tok.line, out_token_line);
        check_field("last", want_tok.last, out_last_of_run);
        kinds_seen[out_token_kind] = 1'b1;
        tokens_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d tokens outstanding", $time, token_q.size());
      $display("byte_stream_tokenizer regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    error_count = 0;
    words_sent = 0;
    tokens_checked = 0;
    cycle_count = 0;
    kinds_seen = '0;
    reset_scanner();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_text();
    test_long_identifier();
    test_backpressure();
    test_random_text();
    test_steady_stream();
    repeat (10) @(posedge clk);
    $display("sent %0d text words, checked %0d tokens covering %0d of 29 token kinds",
             words_sent, tokens_checked, $countones(kinds_seen));
    $display("included a long identifier, a long output hold and end-of-text flushes");
    if (error_count == 0 && token_q.size() == 0) begin
      $display("byte_stream_tokenizer regression: pass");
    end else begin
      $display("byte_stream_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
